// ===== rtl/brb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg: shared types and codes for the byte ring buffer with unget
// Operation codes, controller-to-datapath command, and result payload layout.
// ----------------------------------------------------------------------------
package brb_pkg;

  // operation codes carried in the kind field; code 3 is a failing no-op
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_PULL  = 2'd1;
  localparam logic [1:0] KIND_UNGET = 2'd2;

  localparam int BYTE_W = 8;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // input transfer this cycle: update state, launch read
    logic load;    // move the pending result into the output register
  } brb_cmd_t;

  // one result item
  typedef struct packed {
    logic              done_ok;
    logic [BYTE_W-1:0] read_byte;
    logic [BYTE_W-1:0] fill_count;
    logic              is_empty;
    logic [BYTE_W-1:0] moved_in_call;
  } brb_res_t;

endpackage

`default_nettype wire

// ===== rtl/brb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_if: channel interfaces for the byte ring buffer
// Operation channel (in) and result channel (out), valid/ready handshake.
// ----------------------------------------------------------------------------
interface brb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_in;
  logic       last_of_call;

  modport source (output valid, output kind, output data_in, output last_of_call,
                  input ready);
  modport sink   (input valid, input kind, input data_in, input last_of_call,
                  output ready);
endinterface

interface brb_out_if;
  logic       valid;
  logic       ready;
  logic       done_ok;
  logic [7:0] read_byte;
  logic [7:0] fill_count;
  logic       is_empty;
  logic [7:0] moved_in_call;

  modport source (output valid, output done_ok, output read_byte, output fill_count,
                  output is_empty, output moved_in_call, input ready);
  modport sink   (input valid, input done_ok, input read_byte, input fill_count,
                  input is_empty, input moved_in_call, output ready);
endinterface

`default_nettype wire

// ===== rtl/brb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ctrl: sequencing controller
// Accepts one operation, then waits for a free output register to load it.
// ----------------------------------------------------------------------------
module brb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output brb_pkg::brb_cmd_t     cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_free   = !out_valid_r || out_ready;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.load   = (state_r == ST_LOAD) && out_free;
  assign out_valid  = out_valid_r;

  // state and output-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a load refills the output register, else a transfer empties it
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd.accept) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brb_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_dp: ring buffer datapath
// Byte store, head/tail indices, fill and burst counters, result registers.
// ----------------------------------------------------------------------------
module brb_dp #(
  parameter int DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire brb_pkg::brb_cmd_t cmd,
  input  wire logic [1:0]        kind,
  input  wire logic [7:0]        data_in,
  input  wire logic              last_of_call,
  output brb_pkg::brb_res_t      res
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int FW    = (IDX_W > brb_pkg::BYTE_W) ? IDX_W : brb_pkg::BYTE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] FULL_CNT = IDX_W'(DEPTH - 1);

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_data_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [7:0]       burst_r, burst_nxt;

  // pending result, formed at the input transfer
  logic             p_ok_r, p_pull_r, p_empty_r;
  logic [7:0]       p_fill_r, p_moved_r;
  brb_pkg::brb_res_t res_r;

  logic             is_full, is_emp;
  logic             push_ok, pull_ok, unget_ok, op_ok;
  logic [IDX_W-1:0] head_inc, head_dec, tail_inc;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       moved;
  logic [FW-1:0]    fill_ext;
  logic [7:0]       fill_sat;

  // operation decode
  assign is_full  = (fill_r == FULL_CNT);
  assign is_emp   = (fill_r == '0);
  assign push_ok  = (kind == brb_pkg::KIND_PUSH)  && !is_full;
  assign pull_ok  = (kind == brb_pkg::KIND_PULL)  && !is_emp;
  assign unget_ok = (kind == brb_pkg::KIND_UNGET) && !is_full;
  assign op_ok    = push_ok || pull_ok || unget_ok;

  // modulo-DEPTH index steps
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - IDX_W'(1);
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + IDX_W'(1);

  assign wr_en   = cmd.accept && (push_ok || unget_ok);
  assign rd_en   = cmd.accept && pull_ok;
  assign wr_addr = push_ok ? tail_r : head_dec;

  // next state of indices and counters
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (push_ok) begin
      tail_nxt = tail_inc;
      fill_nxt = fill_r + IDX_W'(1);
    end
    if (pull_ok) begin
      head_nxt = head_inc;
      fill_nxt = fill_r - IDX_W'(1);
    end
    if (unget_ok) begin
      head_nxt = head_dec;
      fill_nxt = fill_r + IDX_W'(1);
    end
  end

  // burst counter saturates, then clears after the last byte of a call
  assign moved     = (op_ok && burst_r != brb_pkg::BYTE_MAX) ? burst_r + 8'd1 : burst_r;
  assign burst_nxt = last_of_call ? '0 : moved;

  assign fill_ext = FW'(fill_nxt);
  assign fill_sat = (fill_ext > FW'(brb_pkg::BYTE_MAX)) ? brb_pkg::BYTE_MAX
                                                         : fill_ext[7:0];

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= data_in;
    end
    if (rd_en) begin
      rd_data_r <= mem[head_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      burst_r <= '0;
    end else if (cmd.accept) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      burst_r <= burst_nxt;
    end
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_ok_r    <= op_ok;
      p_pull_r  <= pull_ok;
      p_empty_r <= (fill_nxt == '0);
      p_fill_r  <= fill_sat;
      p_moved_r <= moved;
    end
    if (cmd.load) begin
      res_r.done_ok       <= p_ok_r;
      res_r.read_byte     <= p_pull_r ? rd_data_r : '0;
      res_r.fill_count    <= p_fill_r;
      res_r.is_empty      <= p_empty_r;
      res_r.moved_in_call <= p_moved_r;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== rtl/byte_ring_buffer_with_unget_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_unget_core: byte ring buffer with push, pull, unget
// Holds up to DEPTH-1 bytes; every operation returns one status result.
// ----------------------------------------------------------------------------
//  channel | dir | transfer when          | payload
//  in_ch   | in  | valid && ready         | kind, data_in, last_of_call
//  out_ch  | out | valid && ready         | done_ok, read_byte, fill_count,
//          |     |                        | is_empty, moved_in_call
//
// An operation runs in order: the transfer cycle updates the indices and
// issues the byte-store read, then the load step moves the pending result
// and read byte into the output register. A stalled output holds the block
// in the load step; the next operation may be taken while a result waits.
// Synchronous active-low reset clears indices, counters and control; the
// byte store is not cleared.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_unget_core #(
  parameter int DEPTH = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  brb_in_if.sink     in_ch,
  brb_out_if.source  out_ch
);

  brb_pkg::brb_cmd_t cmd;
  brb_pkg::brb_res_t res;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  brb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .kind         (in_ch.kind),
    .data_in      (in_ch.data_in),
    .last_of_call (in_ch.last_of_call),
    .res          (res)
  );

  assign out_ch.done_ok       = res.done_ok;
  assign out_ch.read_byte     = res.read_byte;
  assign out_ch.fill_count    = res.fill_count;
  assign out_ch.is_empty      = res.is_empty;
  assign out_ch.moved_in_call = res.moved_in_call;

  // one operation in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while previous operation pending");

  // a failed operation never returns a byte
  a_fail_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.done_ok |-> out_ch.read_byte == 8'd0)
    else $error("read byte on failed operation");

  // empty flag agrees with fill count
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.is_empty == (out_ch.fill_count == 8'd0)))
    else $error("empty flag and fill count disagree");

  // a successful move is always counted
  a_ok_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_ok |-> out_ch.moved_in_call != 8'd0)
    else $error("successful move not counted");

endmodule

`default_nettype wire
